// ===== sv/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the 1-Wire bus master unit.
// ----------------------------------------------------------------------------
package owb_pkg;

    // configuration register file
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int REG_W     = 10;

    // phase counter holds a register value or the reset recovery time
    localparam int CNT_W = 11;

    localparam logic [CNT_W-1:0] RESET_RECOVERY_US = 11'd410;
    localparam int               BITS_PER_BYTE     = 8;

    localparam int QUEUE_DEPTH_DEF = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW_SHORT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_RELEASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_RELEASE_REST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW_TIME     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT      = 3'd7;

    // input kind codes
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_RESET = 3'd1;
    localparam logic [2:0] KIND_WBIT  = 3'd2;
    localparam logic [2:0] KIND_RBIT  = 3'd3;
    localparam logic [2:0] KIND_WBYTE = 3'd4;
    localparam logic [2:0] KIND_RBYTE = 3'd5;
    localparam logic [2:0] KIND_TBYTE = 3'd6;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_RESET = 3'd1,
        CMD_WBIT  = 3'd2,
        CMD_RBIT  = 3'd3,
        CMD_WBYTE = 3'd4,
        CMD_RBYTE = 3'd5,
        CMD_TBYTE = 3'd6,
        CMD_NONE  = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx;
        logic       line;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    function automatic logic [REG_W-1:0] cfg_reset_value(input logic [CFG_IDX_W-1:0] idx);
        logic [REG_W-1:0] v;
        case (idx)
            REG_SLOT_LOW_SHORT:     v = 10'd6;
            REG_WRITE_ONE_RELEASE:  v = 10'd64;
            REG_WRITE_ZERO_LOW:     v = 10'd60;
            REG_WRITE_ZERO_RELEASE: v = 10'd10;
            REG_READ_SAMPLE_WAIT:   v = 10'd9;
            REG_READ_RELEASE_REST:  v = 10'd55;
            REG_RESET_LOW_TIME:     v = 10'd480;
            REG_PRESENCE_WAIT:      v = 10'd70;
            default:                v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// 1-Wire bus master timed by microsecond tick items.
// ----------------------------------------------------------------------------
// Each input item is a tick (one microsecond, with the sampled line level)
// or a command: reset with presence detect, write/read bit, write/read/touch
// byte, LSB first. Every item yields exactly one result giving drive level,
// busy, done, received data, presence and rejection. Items go into a queue of
// QUEUE_DEPTH entries, so input is taken while a result waits on the output.
// The phase sequencer behind the queue takes a command once it is at the
// head and the result register is free. A tick spends one microsecond of the
// running phase and crosses every phase boundary it reaches, zero-length
// phases included, before it leaves the queue. A result is registered and is
// valid in the cycle after its item leaves the queue. Configuration writes
// are registered and always ready.
module one_wire_bus_master_unit #(
    parameter int QUEUE_DEPTH = owb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_kind,
    input  logic [7:0]                    i_tx_byte,
    input  logic                          i_line_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_drive_low,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [7:0]                    o_rx_byte,
    output logic                          o_presence,
    output logic                          o_rejected,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [owb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owb_pkg::REG_W-1:0]     i_cfg_data
);

    owb_pkg::t_head head;
    logic           pop;

    assign o_cfg_ready = 1'b1;

    owb_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_tx_byte    (i_tx_byte),
        .i_line_level (i_line_level),
        .o_head       (head),
        .i_pop        (pop)
    );

    owb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_drive_low (o_drive_low),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rx_byte   (o_rx_byte),
        .o_presence  (o_presence),
        .o_rejected  (o_rejected)
    );

endmodule

// ===== sv/owb_front.sv =====
// ----------------------------------------------------------------------------
// owb_front
// Accepts input items, decodes the kind into a command and queues them.
// ----------------------------------------------------------------------------
module owb_front #(
    parameter int QUEUE_DEPTH = owb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_kind,
    input  logic [7:0]      i_tx_byte,
    input  logic            i_line_level,
    output owb_pkg::t_head  o_head,
    input  logic            i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    owb_pkg::t_item r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    owb_pkg::t_item   in_item;
    logic             push;
    logic             pop;

    function automatic owb_pkg::t_cmd decode_kind(input logic [2:0] kind);
        owb_pkg::t_cmd c;
        case (kind)
            owb_pkg::KIND_TICK:  c = owb_pkg::CMD_TICK;
            owb_pkg::KIND_RESET: c = owb_pkg::CMD_RESET;
            owb_pkg::KIND_WBIT:  c = owb_pkg::CMD_WBIT;
            owb_pkg::KIND_RBIT:  c = owb_pkg::CMD_RBIT;
            owb_pkg::KIND_WBYTE: c = owb_pkg::CMD_WBYTE;
            owb_pkg::KIND_RBYTE: c = owb_pkg::CMD_RBYTE;
            owb_pkg::KIND_TBYTE: c = owb_pkg::CMD_TBYTE;
            default:             c = owb_pkg::CMD_NONE;
        endcase
        return c;
    endfunction

    always_comb begin
        in_item.cmd  = decode_kind(i_kind);
        // write bit sends only bit 0
        in_item.tx   = (in_item.cmd == owb_pkg::CMD_WBIT) ? {7'd0, i_tx_byte[0]} : i_tx_byte;
        in_item.line = i_line_level;
    end

    assign o_ready = (r_cnt != FULL_CNT);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= in_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

endmodule

// ===== sv/owb_back.sv =====
// ----------------------------------------------------------------------------
// owb_back
// Phase sequencer: runs bus slots of queued items one phase step per cycle (the
// last step waits for a free output), holding configuration and result registers.
// ----------------------------------------------------------------------------
module owb_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  owb_pkg::t_head                    i_head,
    output logic                              o_pop,
    input  logic                              i_cfg_valid,
    input  logic [owb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [owb_pkg::REG_W-1:0]         i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_drive_low,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic [7:0]                        o_rx_byte,
    output logic                              o_presence,
    output logic                              o_rejected
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_W1_LOW   = 4'd4,
        PH_W1_REL   = 4'd5,
        PH_W0_LOW   = 4'd6,
        PH_W0_REL   = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_RD_WAIT  = 4'd9,
        PH_RD_REST  = 4'd10
    } t_phase;

    logic [owb_pkg::REG_W-1:0] r_cfg [owb_pkg::CFG_NUM];

    t_phase                    r_phase, n_phase;
    logic [owb_pkg::CNT_W-1:0] r_count, n_count;
    owb_pkg::t_cmd             r_op, n_op;
    logic [2:0]                r_bit, n_bit;
    logic [7:0]                r_send, n_send;
    logic [7:0]                r_recv, n_recv;
    logic                      r_pres, n_pres;
    logic                      r_spent, n_spent;
    logic                      r_out_valid;

    owb_pkg::t_item            item;
    logic                      entered;
    logic                      fin;
    logic                      rej;
    logic                      term;
    logic                      out_free;
    logic                      step_go;
    logic [7:0]                rx;

    function automatic t_phase slot_phase(input owb_pkg::t_cmd op, input logic one);
        t_phase p;
        case (op)
            owb_pkg::CMD_WBIT,
            owb_pkg::CMD_WBYTE: p = one ? PH_W1_LOW : PH_W0_LOW;
            owb_pkg::CMD_TBYTE: p = one ? PH_RD_LOW : PH_W0_LOW;
            default:            p = PH_RD_LOW;
        endcase
        return p;
    endfunction

    function automatic logic [owb_pkg::CNT_W-1:0] phase_len(input t_phase p,
            input logic [owb_pkg::REG_W-1:0] cfg [owb_pkg::CFG_NUM]);
        logic [owb_pkg::REG_W-1:0] v;
        logic [owb_pkg::CNT_W-1:0] len;
        v   = '0;
        len = '0;
        case (p)
            PH_RST_LOW:  v = cfg[owb_pkg::REG_RESET_LOW_TIME];
            PH_RST_WAIT: v = cfg[owb_pkg::REG_PRESENCE_WAIT];
            PH_W1_LOW:   v = cfg[owb_pkg::REG_SLOT_LOW_SHORT];
            PH_W1_REL:   v = cfg[owb_pkg::REG_WRITE_ONE_RELEASE];
            PH_W0_LOW:   v = cfg[owb_pkg::REG_WRITE_ZERO_LOW];
            PH_W0_REL:   v = cfg[owb_pkg::REG_WRITE_ZERO_RELEASE];
            PH_RD_LOW:   v = cfg[owb_pkg::REG_SLOT_LOW_SHORT];
            PH_RD_WAIT:  v = cfg[owb_pkg::REG_READ_SAMPLE_WAIT];
            PH_RD_REST:  v = cfg[owb_pkg::REG_READ_RELEASE_REST];
            default:     v = '0;
        endcase
        len = (p == PH_RST_REC) ? owb_pkg::RESET_RECOVERY_US
                                : {{(owb_pkg::CNT_W-owb_pkg::REG_W){1'b0}}, v};
        return len;
    endfunction

    assign item = i_head.item;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_op    = r_op;
        n_bit   = r_bit;
        n_send  = r_send;
        n_recv  = r_recv;
        n_pres  = r_pres;
        n_spent = r_spent;
        entered = 1'b0;
        fin     = 1'b0;
        rej     = 1'b0;

        case (item.cmd)
            owb_pkg::CMD_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_count == '0) begin
                        // phase over: move to the next one
                        entered = 1'b1;
                        case (r_phase)
                            PH_RST_LOW:  n_phase = PH_RST_WAIT;
                            PH_RST_WAIT: begin
                                n_pres  = ~item.line;
                                n_phase = PH_RST_REC;
                            end
                            PH_W1_LOW:   n_phase = PH_W1_REL;
                            PH_W0_LOW:   n_phase = PH_W0_REL;
                            PH_RD_LOW:   n_phase = PH_RD_WAIT;
                            PH_RD_WAIT:  begin
                                n_recv  = {item.line, r_recv[7:1]};
                                n_phase = PH_RD_REST;
                            end
                            PH_W0_REL,
                            PH_W1_REL,
                            PH_RD_REST:  begin
                                if (r_phase == PH_W0_REL && r_op == owb_pkg::CMD_TBYTE) begin
                                    n_recv = {1'b0, r_recv[7:1]};
                                end
                                if ((r_op == owb_pkg::CMD_WBYTE || r_op == owb_pkg::CMD_RBYTE ||
                                     r_op == owb_pkg::CMD_TBYTE) &&
                                    r_bit < 3'(owb_pkg::BITS_PER_BYTE - 1)) begin
                                    n_bit   = r_bit + 3'd1;
                                    n_send  = {1'b0, r_send[7:1]};
                                    n_phase = slot_phase(r_op, r_send[1]);
                                end else begin
                                    n_phase = PH_IDLE;
                                    fin     = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                fin     = 1'b1;
                            end
                        endcase
                    end else if (!r_spent) begin
                        n_count = r_count - 1'b1;
                        n_spent = 1'b1;
                    end
                end
            end
            owb_pkg::CMD_NONE: begin
            end
            default: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_op    = item.cmd;
                    n_bit   = '0;
                    n_recv  = '0;
                    n_send  = item.tx;
                    n_phase = (item.cmd == owb_pkg::CMD_RESET) ? PH_RST_LOW
                                                               : slot_phase(item.cmd, item.tx[0]);
                    entered = 1'b1;
                end
            end
        endcase

        if (entered) begin
            n_count = phase_len(n_phase, r_cfg);
        end

        // a tick ends on an idle bus, or when counted down with phase time left
        if (item.cmd == owb_pkg::CMD_TICK) begin
            term = (n_phase == PH_IDLE) || ((n_count != '0) && n_spent);
        end else begin
            term = 1'b1;
        end

        rx = '0;
        if (fin) begin
            if (n_op == owb_pkg::CMD_RBIT) begin
                rx = {7'd0, n_recv[7]};
            end else if (n_op == owb_pkg::CMD_RBYTE || n_op == owb_pkg::CMD_TBYTE) begin
                rx = n_recv;
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign step_go  = i_head.valid && (!term || out_free);
    assign o_pop    = i_head.valid && term && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_op        <= owb_pkg::CMD_TICK;
            r_bit       <= '0;
            r_send      <= '0;
            r_recv      <= '0;
            r_pres      <= 1'b0;
            r_spent     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < owb_pkg::CFG_NUM; i++) begin
                r_cfg[i] <= owb_pkg::cfg_reset_value(owb_pkg::CFG_IDX_W'(i));
            end
        end else begin
            if (i_cfg_valid) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            if (step_go) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_op    <= n_op;
                r_bit   <= n_bit;
                r_send  <= n_send;
                r_recv  <= n_recv;
                r_pres  <= n_pres;
                r_spent <= term ? 1'b0 : n_spent;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_drive_low <= (n_phase == PH_RST_LOW) || (n_phase == PH_W1_LOW) ||
                           (n_phase == PH_W0_LOW)  || (n_phase == PH_RD_LOW);
            o_busy_res  <= (n_phase != PH_IDLE);
            o_done_res  <= fin;
            o_rx_byte   <= rx;
            o_presence  <= n_pres;
            o_rejected  <= rej;
        end
    end

    assign o_valid = r_out_valid;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_drive_low |-> o_busy_res)
        else $error("bus driven low while idle");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_rejected |-> o_busy_res && !o_done_res)
        else $error("rejection without a running command");

    a_rx_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_done_res |-> o_rx_byte == 8'd0)
        else $error("receive data outside done");

    a_spent_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spent |-> i_head.valid && item.cmd == owb_pkg::CMD_TICK)
        else $error("spent flag left over without a tick in progress");

endmodule
